/* rtl/core/page_translate_clock_replace_defines.svh */
// Assertion macros for the page translation block.
`ifndef PAGE_TRANSLATE_CLOCK_REPLACE_DEFINES_SVH
`define PAGE_TRANSLATE_CLOCK_REPLACE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PTCR_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTCR_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ptcr_pkg.sv */
// Shared constants and controller/datapath types for the page translation block.
package ptcr_pkg;

    localparam int NUM_FRAMES     = 16;
    localparam int ADDR_BITS      = 32;
    localparam int FRAME_BITS     = $clog2(NUM_FRAMES);
    localparam int FRAME_CNT_BITS = $clog2(NUM_FRAMES + 1);
    localparam int PHYS_BITS      = 35;
    localparam int COUNT_BITS     = 32;
    localparam int SHIFT_BITS     = 5;
    localparam int CFG_DATA_BITS  = 5;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAGE_SHIFT    = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] FRAMES_RESET = CFG_DATA_BITS'(16);
    localparam logic [CFG_DATA_BITS-1:0] SHIFT_RESET  = CFG_DATA_BITS'(12);

    typedef struct packed {
        logic load;
        logic commit_lookup;
        logic start_sweep;
        logic clear_step;
        logic commit_victim;
    } ptcr_cmd_t;

    typedef struct packed {
        logic hit;
        logic free_found;
        logic ref_at_hand;
        logic out_free;
    } ptcr_status_t;

endpackage

/* rtl/core/ptcr_req_if.sv */
// Request channel carrying one virtual address per transfer.
interface ptcr_req_if;
    logic                           valid;
    logic                           ready;
    logic [ptcr_pkg::ADDR_BITS-1:0] virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink (input valid, input virtual_address, output ready);
endinterface

/* rtl/core/ptcr_rsp_if.sv */
// Result channel carrying one translation result per transfer.
interface ptcr_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [ptcr_pkg::FRAME_BITS-1:0] frame_index;
    logic [ptcr_pkg::PHYS_BITS-1:0]  physical_address;
    logic [ptcr_pkg::COUNT_BITS-1:0] reference_count;
    logic [ptcr_pkg::COUNT_BITS-1:0] fault_count;

    modport source (output valid, output hit, output frame_index, output physical_address,
                    output reference_count, output fault_count, input ready);
    modport sink (input valid, input hit, input frame_index, input physical_address,
                  input reference_count, input fault_count, output ready);
endinterface

/* rtl/core/ptcr_ctrl.sv */
// Controller state machine sequencing lookup, clock sweep and result commit.
module ptcr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ptcr_pkg::ptcr_status_t status,
    output ptcr_pkg::ptcr_cmd_t    cmd
);
    import ptcr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_SWEEP  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (status.hit || status.free_found)
                begin
                    if (status.out_free)
                    begin
                        cmd.commit_lookup = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
                else
                begin
                    cmd.start_sweep = 1'b1;
                    state_next      = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (status.ref_at_hand)
                begin
                    cmd.clear_step = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.commit_victim = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/ptcr_datapath.sv */
// Frame table, clock hand, counters, configuration and result register.
module ptcr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ptcr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ptcr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [ptcr_pkg::ADDR_BITS-1:0]      virtual_address,
    input  ptcr_pkg::ptcr_cmd_t                 cmd,
    output ptcr_pkg::ptcr_status_t              status,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic                                hit,
    output logic [ptcr_pkg::FRAME_BITS-1:0]     frame_index,
    output logic [ptcr_pkg::PHYS_BITS-1:0]      physical_address,
    output logic [ptcr_pkg::COUNT_BITS-1:0]     reference_count,
    output logic [ptcr_pkg::COUNT_BITS-1:0]     fault_count
);
    import ptcr_pkg::*;

    logic [CFG_DATA_BITS-1:0]  frames_cfg_reg;
    logic [SHIFT_BITS-1:0]     shift_reg;
    logic [ADDR_BITS-1:0]      page_reg;
    logic [ADDR_BITS-1:0]      offset_reg;
    logic [ADDR_BITS-1:0]      frame_page_reg [NUM_FRAMES];
    logic [NUM_FRAMES-1:0]     valid_reg;
    logic [NUM_FRAMES-1:0]     refd_reg;
    logic [FRAME_BITS-1:0]     hand_reg;
    logic [FRAME_BITS-1:0]     sweep_reg;
    logic [COUNT_BITS-1:0]     refs_reg;
    logic [COUNT_BITS-1:0]     faults_reg;
    logic                      out_valid_reg;

    logic [FRAME_CNT_BITS-1:0] n_eff;
    logic [NUM_FRAMES-1:0]     match;
    logic [NUM_FRAMES-1:0]     free;
    logic                      hit_found;
    logic                      free_found;
    logic [FRAME_BITS-1:0]     hit_idx;
    logic [FRAME_BITS-1:0]     free_idx;
    logic                      commit;
    logic                      commit_hit;
    logic [FRAME_BITS-1:0]     commit_frame;
    logic [COUNT_BITS-1:0]     refs_next;
    logic [COUNT_BITS-1:0]     faults_next;
    logic                      out_free;

    function automatic logic [FRAME_BITS-1:0] wrap_next(
        input logic [FRAME_BITS-1:0]     f,
        input logic [FRAME_CNT_BITS-1:0] n
    );
        logic [FRAME_CNT_BITS-1:0] inc;
        inc = FRAME_CNT_BITS'(f) + FRAME_CNT_BITS'(1);
        return (inc < n) ? inc[FRAME_BITS-1:0] : '0;
    endfunction

    always_comb
    begin
        if (frames_cfg_reg == '0)
        begin
            n_eff = FRAME_CNT_BITS'(1);
        end
        else if (FRAME_CNT_BITS'(frames_cfg_reg) > FRAME_CNT_BITS'(NUM_FRAMES))
        begin
            n_eff = FRAME_CNT_BITS'(NUM_FRAMES);
        end
        else
        begin
            n_eff = FRAME_CNT_BITS'(frames_cfg_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            match[i] = valid_reg[i] && (frame_page_reg[i] == page_reg)
                       && (FRAME_CNT_BITS'(i) < n_eff);
            free[i]  = !valid_reg[i] && (FRAME_CNT_BITS'(i) < n_eff);
        end
    end

    // The lowest-numbered matching or free frame wins.
    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_found = 1'b1;
                hit_idx   = FRAME_BITS'(i);
            end
            if (free[i])
            begin
                free_found = 1'b1;
                free_idx   = FRAME_BITS'(i);
            end
        end
    end

    assign commit       = cmd.commit_lookup || cmd.commit_victim;
    assign commit_hit   = cmd.commit_lookup && hit_found;
    assign commit_frame = cmd.commit_victim ? sweep_reg : (hit_found ? hit_idx : free_idx);
    assign refs_next    = (refs_reg == '1) ? refs_reg : refs_reg + COUNT_BITS'(1);
    assign faults_next  = (commit_hit || faults_reg == '1) ? faults_reg
                                                           : faults_reg + COUNT_BITS'(1);
    assign out_free     = !out_valid_reg || rsp_ready;

    assign status.hit         = hit_found;
    assign status.free_found  = free_found;
    assign status.ref_at_hand = refd_reg[sweep_reg];
    assign status.out_free    = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg_reg <= FRAMES_RESET;
            shift_reg      <= SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAMES_IN_USE: frames_cfg_reg <= cfg_data;
                REG_PAGE_SHIFT:    shift_reg      <= SHIFT_BITS'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg   <= virtual_address >> shift_reg;
            offset_reg <= virtual_address & ~({ADDR_BITS{1'b1}} << shift_reg);
        end
        if (commit && !commit_hit)
        begin
            frame_page_reg[commit_frame] <= page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            refd_reg   <= '0;
            hand_reg   <= '0;
            sweep_reg  <= '0;
            refs_reg   <= '0;
            faults_reg <= '0;
        end
        else
        begin
            if (cmd.start_sweep)
            begin
                sweep_reg <= (FRAME_CNT_BITS'(hand_reg) < n_eff) ? hand_reg : '0;
            end
            else if (cmd.clear_step)
            begin
                refd_reg[sweep_reg] <= 1'b0;
                sweep_reg           <= wrap_next(sweep_reg, n_eff);
            end
            if (commit)
            begin
                valid_reg[commit_frame] <= 1'b1;
                refd_reg[commit_frame]  <= 1'b1;
                refs_reg                <= refs_next;
                faults_reg              <= faults_next;
                if (!commit_hit)
                begin
                    hand_reg <= wrap_next(commit_frame, n_eff);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            hit              <= commit_hit;
            frame_index      <= commit_frame;
            physical_address <= (PHYS_BITS'(commit_frame) << shift_reg)
                                | PHYS_BITS'(offset_reg);
            reference_count  <= refs_next;
            fault_count      <= faults_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

/* rtl/core/page_translate_clock_replace.sv */
// Top level of the page translation block with clock page replacement.
// Each address transfer yields one result transfer. For a hit, or a fault that finds a free
// frame, the controller first accepts the address and splits page from offset, then does
// the parallel compare over all frames and the commit into the result register. A fault
// with every frame in use adds a clock sweep in which the hand visits one frame more than
// the number of reference bits it clears, up to frames_in_use plus one. A result that is
// not taken stalls the commit; the next address is accepted only after the current one
// has committed.
module page_translate_clock_replace (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ptcr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ptcr_pkg::CFG_DATA_BITS-1:0] cfg_data,
    ptcr_req_if.sink                           req,
    ptcr_rsp_if.source                         rsp
);
    import ptcr_pkg::*;

    `include "page_translate_clock_replace_defines.svh"

    ptcr_cmd_t    cmd;
    ptcr_status_t status;

    ptcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ptcr_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .virtual_address  (req.virtual_address),
        .cmd              (cmd),
        .status           (status),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .hit              (rsp.hit),
        .frame_index      (rsp.frame_index),
        .physical_address (rsp.physical_address),
        .reference_count  (rsp.reference_count),
        .fault_count      (rsp.fault_count)
    );

    `PTCR_ASSERT_NXT(a_one_item_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready, "address accepted while an item is in flight")
    `PTCR_ASSERT_NXT(a_commit_shows_result, clk, rst_n, cmd.commit_lookup || cmd.commit_victim, rsp.valid, "committed result not presented")
    `PTCR_ASSERT_IMP(a_no_clear_on_commit, clk, rst_n, cmd.clear_step, !cmd.commit_victim && !cmd.commit_lookup, "reference clear during commit")
    `PTCR_ASSERT_IMP(a_faults_within_refs, clk, rst_n, rsp.valid, rsp.fault_count <= rsp.reference_count, "fault count exceeds reference count")

endmodule

/* bench/page_translate_clock_replace_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for the page translation block: directed table, then random phases.
module page_translate_clock_replace_test;
    import ptcr_pkg::*;

    localparam int RANDOM_ITEMS = 1530;
    localparam int CALM_ITEMS   = 200;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * (NUM_FRAMES + 3);
    localparam int PRINT_LIMIT  = 50;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_index;
        logic [PHYS_BITS-1:0]  physical_address;
        logic [COUNT_BITS-1:0] reference_count;
        logic [COUNT_BITS-1:0] fault_count;
    } xlat_t;

    typedef enum logic {STEP_CONFIG, STEP_ADDRESS} step_kind_t;

    typedef struct {
        step_kind_t               kind;
        logic [CFG_IDX_BITS-1:0]  reg_index;
        logic [CFG_DATA_BITS-1:0] reg_value;
        logic [ADDR_BITS-1:0]     virtual_address;
        bit                       typed;
        xlat_t                    want;
    } step_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    ptcr_req_if req_ch ();
    ptcr_rsp_if rsp_ch ();

    page_translate_clock_replace DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    logic                     model_valid [NUM_FRAMES];
    logic [ADDR_BITS-1:0]     model_page [NUM_FRAMES];
    logic                     model_referenced [NUM_FRAMES];
    int unsigned              model_hand;
    logic [COUNT_BITS-1:0]    model_refs;
    logic [COUNT_BITS-1:0]    model_faults;
    logic [CFG_DATA_BITS-1:0] model_frames_cfg;
    logic [CFG_DATA_BITS-1:0] model_shift;

    xlat_t expected_xlat [$];
    int    items_sent = 0;
    int    results_checked = 0;
    int    hits_seen = 0;
    int    mismatch_count = 0;
    int    quiet_cycles = 0;
    int    idle_pct = 0;
    int    ready_stall = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned frames_managed(input logic [CFG_DATA_BITS-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > NUM_FRAMES)
            return NUM_FRAMES;
        return 32'(setting);
    endfunction

    function automatic xlat_t translate_address(input logic [ADDR_BITS-1:0] va);
        int unsigned          n;
        int unsigned          h;
        int unsigned          frame;
        int                   i;
        logic [ADDR_BITS-1:0] page;
        logic [ADDR_BITS-1:0] offset;
        logic                 hit;
        logic                 found;
        xlat_t                r;
        n = frames_managed(model_frames_cfg);
        offset = va & ((ADDR_BITS'(1) << model_shift) - ADDR_BITS'(1));
        page = va >> model_shift;
        hit = 1'b0;
        found = 1'b0;
        frame = 0;
        if (model_refs != '1)
            model_refs++;
        for (i = 0; i < n; i++)
        begin
            if (!hit && model_valid[i] && model_page[i] == page)
            begin
                hit = 1'b1;
                frame = i;
                model_referenced[i] = 1'b1;
            end
        end
        if (!hit)
        begin
            if (model_faults != '1)
                model_faults++;
            for (i = 0; i < n; i++)
            begin
                if (!found && !model_valid[i])
                begin
                    frame = i;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                h = (model_hand < n) ? model_hand : 0;
                while (model_referenced[h])
                begin
                    model_referenced[h] = 1'b0;
                    h = (h + 1 < n) ? h + 1 : 0;
                end
                frame = h;
            end
            model_valid[frame] = 1'b1;
            model_page[frame] = page;
            model_referenced[frame] = 1'b1;
            model_hand = (frame + 1 < n) ? frame + 1 : 0;
        end
        r.hit = hit;
        r.frame_index = FRAME_BITS'(frame);
        r.physical_address = (PHYS_BITS'(frame) << model_shift) | PHYS_BITS'(offset);
        r.reference_count = model_refs;
        r.fault_count = model_faults;
        return r;
    endfunction

    function automatic step_t set_register(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] value);
        step_t s;
        s.kind = STEP_CONFIG;
        s.reg_index = idx;
        s.reg_value = value;
        s.virtual_address = '0;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic step_t at_address(input logic [ADDR_BITS-1:0] va);
        step_t s;
        s.kind = STEP_ADDRESS;
        s.reg_index = '0;
        s.reg_value = '0;
        s.virtual_address = va;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic step_t checked_address(input logic [ADDR_BITS-1:0] va, input xlat_t want);
        step_t s;
        s = at_address(va);
        s.typed = 1'b1;
        s.want = want;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_FRAMES_IN_USE)
            model_frames_cfg = value;
        else
            model_shift = value;
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_xlat.size() != 0);
    endtask

    task automatic hold_off(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_address(input logic [ADDR_BITS-1:0] va, input bit typed,
                                input xlat_t want);
        xlat_t predicted;
        req_ch.valid <= 1'b1;
        req_ch.virtual_address <= va;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = translate_address(va);
        expected_xlat.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        if (ready_stall != 0)
        begin
            rsp_ch.ready <= 1'b0;
            ready_stall--;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            rsp_ch.ready <= 1'b0;
            ready_stall = $urandom_range(0, 13);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        xlat_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_xlat.size() == 0)
                report_mismatch("result transfer with none expected", 0, 0);
            else
            begin
                want = expected_xlat.pop_front();
                results_checked++;
                if (rsp_ch.hit)
                    hits_seen++;
                if (rsp_ch.hit !== want.hit)
                    report_mismatch("hit", rsp_ch.hit, want.hit);
                if (rsp_ch.frame_index !== want.frame_index)
                    report_mismatch("frame_index", rsp_ch.frame_index, want.frame_index);
                if (rsp_ch.physical_address !== want.physical_address)
                    report_mismatch("physical_address", rsp_ch.physical_address,
                                    want.physical_address);
                if (rsp_ch.reference_count !== want.reference_count)
                    report_mismatch("reference_count", rsp_ch.reference_count,
                                    want.reference_count);
                if (rsp_ch.fault_count !== want.fault_count)
                    report_mismatch("fault_count", rsp_ch.fault_count, want.fault_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("No transfer for %0d cycles at %0t", QUIET_LIMIT, $time);
        $display("page_translate_clock_replace verification failed");
        $finish;
    end

    initial
    begin
        step_t                    steps [$];
        logic [ADDR_BITS-1:0]     page_pool [$];
        logic [ADDR_BITS-1:0]     offset_mask;
        logic [ADDR_BITS-1:0]     va;
        logic [CFG_DATA_BITS-1:0] frames_setting;
        logic [CFG_DATA_BITS-1:0] shift_setting;
        int                       random_sent;
        int                       phase_len;
        int                       idle_mode;
        int                       phases;
        int                       directed_items;

        req_ch.valid = 1'b0;
        req_ch.virtual_address = '0;
        rsp_ch.ready = 1'b0;
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            model_valid[f] = 1'b0;
            model_page[f] = '0;
            model_referenced[f] = 1'b0;
        end
        model_hand = 0;
        model_refs = '0;
        model_faults = '0;
        model_frames_cfg = FRAMES_RESET;
        model_shift = SHIFT_RESET;

        steps.push_back(checked_address(32'h0000_0000, '{1'b0, 4'd0, 35'h0, 32'd1, 32'd1}));
        steps.push_back(checked_address(32'hFFFF_FFFF, '{1'b0, 4'd1, 35'h1FFF, 32'd2, 32'd2}));
        steps.push_back(checked_address(32'h0000_0ABC, '{1'b1, 4'd0, 35'hABC, 32'd3, 32'd2}));
        steps.push_back(set_register(REG_FRAMES_IN_USE, 5'd2));
        steps.push_back(at_address(32'h0000_5000));
        steps.push_back(at_address(32'h0000_1000));
        steps.push_back(at_address(32'h0000_5004));
        steps.push_back(set_register(REG_FRAMES_IN_USE, 5'd0));
        steps.push_back(set_register(REG_PAGE_SHIFT, 5'd0));
        steps.push_back(at_address(32'h1234_5678));
        steps.push_back(at_address(32'h1234_5678));
        steps.push_back(at_address(32'h8765_4321));
        steps.push_back(set_register(REG_FRAMES_IN_USE, 5'd31));
        steps.push_back(set_register(REG_PAGE_SHIFT, 5'd31));
        steps.push_back(at_address(32'hFFFF_FFFF));
        steps.push_back(at_address(32'h8000_0000));
        steps.push_back(at_address(32'h7FFF_FFFF));
        steps.push_back(at_address(32'h0000_0000));
        steps.push_back(set_register(REG_FRAMES_IN_USE, 5'd16));
        steps.push_back(set_register(REG_PAGE_SHIFT, 5'd12));
        steps.push_back(at_address(32'h0000_1000));
        steps.push_back(at_address(32'h0000_2000));
        steps.push_back(at_address(32'h0000_3000));
        steps.push_back(at_address(32'h0000_4000));
        steps.push_back(at_address(32'h0000_5000));
        steps.push_back(set_register(REG_FRAMES_IN_USE, 5'd1));
        steps.push_back(at_address(32'h0000_3000));
        steps.push_back(set_register(REG_FRAMES_IN_USE, 5'd16));
        steps.push_back(at_address(32'h0000_3FFF));
        steps.push_back(at_address(32'hFFFF_F123));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[s])
        begin
            if (steps[s].kind == STEP_CONFIG)
            begin
                wait_for_results();
                write_register(steps[s].reg_index, steps[s].reg_value);
            end
            else
                send_address(steps[s].virtual_address, steps[s].typed, steps[s].want);
        end
        directed_items = items_sent;

        random_sent = 0;
        phases = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_for_results();
            case ($urandom_range(0, 7))
                0: frames_setting = '0;
                1: frames_setting = 5'd1;
                2: frames_setting = CFG_DATA_BITS'(NUM_FRAMES);
                3: frames_setting = '1;
                4: frames_setting = CFG_DATA_BITS'($urandom_range(NUM_FRAMES + 1, 30));
                default: frames_setting = CFG_DATA_BITS'($urandom_range(2, NUM_FRAMES - 1));
            endcase
            case ($urandom_range(0, 5))
                0: shift_setting = '0;
                1: shift_setting = '1;
                default: shift_setting = CFG_DATA_BITS'($urandom_range(1, 30));
            endcase
            write_register(REG_FRAMES_IN_USE, frames_setting);
            write_register(REG_PAGE_SHIFT, shift_setting);
            phases++;

            page_pool.delete();
            repeat (frames_managed(frames_setting) + $urandom_range(1, 8))
                page_pool.push_back($urandom() >> shift_setting);
            offset_mask = (ADDR_BITS'(1) << shift_setting) - ADDR_BITS'(1);
            case ($urandom_range(0, 2))
                0: idle_mode = 0;
                1: idle_mode = 8;
                default: idle_mode = 35;
            endcase

            phase_len = $urandom_range(40, 160);
            while (phase_len > 0 && random_sent < RANDOM_ITEMS)
            begin
                if (random_sent >= RANDOM_ITEMS - CALM_ITEMS)
                    idle_mode = 0;
                idle_pct <= idle_mode;
                if (idle_mode != 0 && $urandom_range(0, 99) < idle_mode)
                    hold_off($urandom_range(1, 14));
                if ($urandom_range(0, 9) == 0)
                    va = $urandom();
                else
                    va = (page_pool[$urandom_range(0, page_pool.size() - 1)] << shift_setting)
                         | ($urandom() & offset_mask);
                send_address(va, 1'b0, '0);
                random_sent++;
                phase_len--;
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Translated %0d addresses (%0d directed, %0d random over %0d settings phases).",
                 items_sent, directed_items, random_sent, phases);
        $display("Checked %0d results: %0d hits, %0d faults, %0d mismatches.",
                 results_checked, hits_seen, results_checked - hits_seen, mismatch_count);
        if (mismatch_count == 0 && expected_xlat.size() == 0)
            $display("page_translate_clock_replace verification clean");
        else
            $display("page_translate_clock_replace verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ptcr_pkg.sv
rtl/core/ptcr_req_if.sv
rtl/core/ptcr_rsp_if.sv
rtl/core/ptcr_ctrl.sv
rtl/core/ptcr_datapath.sv
rtl/core/page_translate_clock_replace.sv
bench/page_translate_clock_replace_test.sv
